@@ design/btb_pkg.sv @@
package btb_pkg;

  localparam int BYTE_W = 8;
  localparam int DIM_CFG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam int DEFAULT_MAX_ROWS = 8;
  localparam int DEFAULT_MAX_COLS = 8;

  localparam logic [DIM_CFG_W-1:0] RST_GRID_ROWS = 4'd8;
  localparam logic [DIM_CFG_W-1:0] RST_GRID_COLS = 4'd8;
  localparam logic RST_READ_BY_COLUMNS = 1'b1;
  localparam logic [BYTE_W-1:0] RST_PAD_BYTE = 8'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1,
    REG_READ_BY_COLUMNS = 2'd2,
    REG_PAD_BYTE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic close;
    logic scan_end;
  } dp_status_t;

endpackage

@@ design/btb_ctrl.sv @@
module btb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  btb_pkg::dp_status_t sts,
  output btb_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  btb_pkg::state_t state;
  btb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      btb_pkg::ST_IDLE: begin
        if (start && sts.close) begin
          state_next = btb_pkg::ST_SCAN;
        end
      end
      btb_pkg::ST_SCAN: begin
        if (sts.scan_end) begin
          state_next = btb_pkg::ST_DRAIN;
        end
      end
      btb_pkg::ST_DRAIN: begin
        state_next = btb_pkg::ST_IDLE;
      end
      default: begin
        state_next = btb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      btb_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.accept = start;
      end
      btb_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      btb_pkg::ST_DRAIN: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ design/btb_dp.sv @@
module btb_dp #(
  parameter int MAX_ROWS = btb_pkg::DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = btb_pkg::DEFAULT_MAX_COLS,
  parameter int DIM_W = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  btb_pkg::ctrl_cmd_t         cmd,
  output btb_pkg::dp_status_t        sts,
  input  logic [DIM_W-1:0]           rows,
  input  logic [DIM_W-1:0]           cols,
  input  logic                       read_by_columns,
  input  logic [btb_pkg::BYTE_W-1:0] pad_byte,
  input  logic [btb_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_last,
  output logic                       strobe,
  output logic [btb_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ADDR_W + 1;

  logic [btb_pkg::BYTE_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  cap;
  logic              fill_inc;
  logic [CNT_W-1:0]  fill_after;
  logic [DIM_W-1:0]  inner;
  logic [DIM_W-1:0]  outer;
  logic [ADDR_W-1:0] src;
  logic [DIM_W-1:0]  stride;
  logic [DIM_W-1:0]  inner_max;
  logic [DIM_W-1:0]  outer_max;
  logic              inner_end;
  logic [SUM_W-1:0]  src_step;
  logic [SUM_W-1:0]  src_wrap;

  logic [btb_pkg::BYTE_W-1:0] rd_data;
  logic                       use_pad;

  assign cap = CNT_W'(CNT_W'(rows) * CNT_W'(cols));
  assign fill_inc = (fill_count < cap);
  assign fill_after = fill_count + CNT_W'(fill_inc);
  assign sts.close = in_last || (fill_after >= cap);

  assign stride = read_by_columns ? cols : rows;
  assign inner_max = read_by_columns ? rows : cols;
  assign outer_max = read_by_columns ? cols : rows;
  assign inner_end = (inner == inner_max - DIM_W'(1));
  assign sts.scan_end = inner_end && (outer == outer_max - DIM_W'(1));
  assign src_step = SUM_W'(src) + SUM_W'(stride);
  assign src_wrap = SUM_W'(outer) + SUM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.finish) begin
      fill_count <= '0;
    end else if (cmd.accept) begin
      fill_count <= fill_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && fill_inc) begin
      mem[fill_count[ADDR_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      inner <= '0;
      outer <= '0;
      src <= '0;
    end else if (cmd.scan) begin
      if (inner_end) begin
        inner <= '0;
        outer <= outer + DIM_W'(1);
        src <= src_wrap[ADDR_W-1:0];
      end else begin
        inner <= inner + DIM_W'(1);
        src <= src_step[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= mem[src];
      use_pad <= (CNT_W'(src) >= fill_count);
      out_last <= sts.scan_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.scan;
    end
  end

  assign out_byte = use_pad ? pad_byte : rd_data;

endmodule

@@ design/block_transposition_buffer_core.sv @@
// Channel   Handshake                 Payload
// input     start, busy               in_byte, in_last
// result    strobe                    out_byte, out_last
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// An input beat is taken when start is high and busy is low; a beat that fills or
// closes the grid is then followed by rows * cols result beats, one a cycle from
// the single read port of the grid memory, with busy high until the last is shown.
// Synchronous reset clears controller, fill count and strobe and presets config.
// Results are shown for one cycle each and cannot be held off by the receiver.
module block_transposition_buffer_core #(
  parameter int MAX_ROWS = btb_pkg::DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = btb_pkg::DEFAULT_MAX_COLS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [btb_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           in_last,
  output logic                           strobe,
  output logic [btb_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [btb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CW = btb_pkg::DIM_CFG_W;
  localparam logic [CW-1:0] ROWS_LIM = CW'(MAX_ROWS);
  localparam logic [CW-1:0] COLS_LIM = CW'(MAX_COLS);

  logic [CW-1:0]             grid_rows;
  logic [CW-1:0]             grid_cols;
  logic                      read_by_columns;
  logic [btb_pkg::BYTE_W-1:0] pad_byte;
  logic [CW-1:0]             rows_clamped;
  logic [CW-1:0]             cols_clamped;

  btb_pkg::ctrl_cmd_t  cmd;
  btb_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= btb_pkg::RST_GRID_ROWS;
      grid_cols <= btb_pkg::RST_GRID_COLS;
      read_by_columns <= btb_pkg::RST_READ_BY_COLUMNS;
      pad_byte <= btb_pkg::RST_PAD_BYTE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (btb_pkg::cfg_reg_t'(cfg_index))
        btb_pkg::REG_GRID_ROWS:       grid_rows <= cfg_data[CW-1:0];
        btb_pkg::REG_GRID_COLS:       grid_cols <= cfg_data[CW-1:0];
        btb_pkg::REG_READ_BY_COLUMNS: read_by_columns <= cfg_data[0];
        btb_pkg::REG_PAD_BYTE:        pad_byte <= cfg_data[btb_pkg::BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (grid_rows == '0) begin
      rows_clamped = CW'(1);
    end else if (grid_rows > ROWS_LIM) begin
      rows_clamped = ROWS_LIM;
    end else begin
      rows_clamped = grid_rows;
    end
  end

  always_comb begin
    priority if (grid_cols == '0) begin
      cols_clamped = CW'(1);
    end else if (grid_cols > COLS_LIM) begin
      cols_clamped = COLS_LIM;
    end else begin
      cols_clamped = grid_cols;
    end
  end

  btb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  btb_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .DIM_W    (DIM_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .rows            (rows_clamped[DIM_W-1:0]),
    .cols            (cols_clamped[DIM_W-1:0]),
    .read_by_columns (read_by_columns),
    .pad_byte        (pad_byte),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .strobe          (strobe),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

endmodule

@@ tb/sv/tb.sv @@
module tb;

  localparam int MAX_ROWS = btb_pkg::DEFAULT_MAX_ROWS;
  localparam int MAX_COLS = btb_pkg::DEFAULT_MAX_COLS;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 300;

  typedef struct packed {
    logic [btb_pkg::BYTE_W-1:0] data;
    logic                       last;
  } out_beat_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic [btb_pkg::BYTE_W-1:0]     in_byte = '0;
  logic                           in_last = 1'b0;
  logic                           cfg_valid = 1'b0;
  btb_pkg::cfg_reg_t              cfg_index = btb_pkg::REG_GRID_ROWS;
  logic [btb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           busy;
  logic                           strobe;
  logic [btb_pkg::BYTE_W-1:0]     out_byte;
  logic                           out_last;
  logic                           cfg_ready;

  block_transposition_buffer_core #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .in_byte(in_byte),
    .in_last(in_last),
    .strobe(strobe),
    .out_byte(out_byte),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [btb_pkg::BYTE_W-1:0]    grid_copy [CELLS];
  int unsigned                   held_bytes = 0;
  logic [btb_pkg::DIM_CFG_W-1:0] rows_cfg = btb_pkg::RST_GRID_ROWS;
  logic [btb_pkg::DIM_CFG_W-1:0] cols_cfg = btb_pkg::RST_GRID_COLS;
  logic                          by_cols_cfg = btb_pkg::RST_READ_BY_COLUMNS;
  logic [btb_pkg::BYTE_W-1:0]    pad_cfg = btb_pkg::RST_PAD_BYTE;
  out_beat_t                     pending_bytes [$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  beats_checked = 0;
  int  settings_used = 0;
  int  cycles = 0;
  bit  no_gaps = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               pending_bytes.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(logic [btb_pkg::DIM_CFG_W-1:0] v,
                                            int unsigned maxv);
    if (v == 0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void transpose_step(logic [btb_pkg::BYTE_W-1:0] b, logic l);
    int unsigned rows;
    int unsigned cols;
    int unsigned cap;
    int unsigned src;
    int unsigned k;
    out_beat_t   beat;
    rows = clamp_dim(rows_cfg, MAX_ROWS);
    cols = clamp_dim(cols_cfg, MAX_COLS);
    cap = rows * cols;
    if (held_bytes < cap) begin
      grid_copy[CELL_W'(held_bytes)] = b;
      held_bytes++;
    end
    if (held_bytes < cap && !l) return;
    k = 0;
    for (int unsigned o = 0; o < (by_cols_cfg ? cols : rows); o++) begin
      for (int unsigned i = 0; i < (by_cols_cfg ? rows : cols); i++) begin
        src = by_cols_cfg ? i * cols + o : i * rows + o;
        beat.data = (src < held_bytes) ? grid_copy[CELL_W'(src)] : pad_cfg;
        beat.last = (k == cap - 1);
        pending_bytes.push_back(beat);
        k++;
      end
    end
    held_bytes = 0;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch on %s: got %0d, want %0d (beat %0d)", what, got, want,
             beats_checked);
  endtask

  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (!rst && strobe) begin
      if (pending_bytes.size() == 0) begin
        report("unexpected beat", int'(out_byte), -1);
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data) report("out_byte", int'(out_byte), int'(want.data));
        if (out_last !== want.last) report("out_last", int'(out_last), int'(want.last));
      end
      beats_checked++;
    end
  end

  task automatic send_byte(logic [btb_pkg::BYTE_W-1:0] b, logic l);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (busy);
    transpose_step(b, l);
    bytes_sent++;
  endtask

  task automatic pause_sender();
    start <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(btb_pkg::cfg_reg_t idx, logic [btb_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      btb_pkg::REG_GRID_ROWS:       rows_cfg = data[btb_pkg::DIM_CFG_W-1:0];
      btb_pkg::REG_GRID_COLS:       cols_cfg = data[btb_pkg::DIM_CFG_W-1:0];
      btb_pkg::REG_READ_BY_COLUMNS: by_cols_cfg = data[0];
      btb_pkg::REG_PAD_BYTE:        pad_cfg = data[btb_pkg::BYTE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [7:0] raw_rows, logic [7:0] raw_cols, logic mode,
                          logic [7:0] pad);
    pause_sender();
    repeat (4) @(posedge clk);
    cfg_write(btb_pkg::REG_GRID_ROWS, raw_rows);
    cfg_write(btb_pkg::REG_GRID_COLS, raw_cols);
    cfg_write(btb_pkg::REG_READ_BY_COLUMNS, {7'($urandom_range(0, 127)), mode});
    cfg_write(btb_pkg::REG_PAD_BYTE, pad);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_read_orders();
    set_grid(8'd2, 8'd2, 1'b1, 8'h00);
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    set_grid(8'd2, 8'd2, 1'b0, 8'hff);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
  endtask

  task automatic test_single_cell();
    set_grid(8'd1, 8'd1, 1'b1, 8'h55);
    send_byte(8'haa, 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  task automatic test_clamped_sizes();
    set_grid(8'h00, 8'hff, 1'b1, 8'h3c);
    send_byte(8'hc3, 1'b1);
    set_grid(8'd9, 8'h10, 1'b0, 8'hc3);
    send_byte(8'h3c, 1'b1);
  endtask

  task automatic test_mid_message_changes();
    set_grid(8'd4, 8'd4, 1'b1, 8'h99);
    for (int i = 0; i < 5; i++) send_byte(8'(8'h10 + i), 1'b0);
    // The grid now holds more than it can, so the next byte is dropped.
    set_grid(8'd2, 8'd2, 1'b1, 8'h99);
    send_byte(8'hee, 1'b0);
    set_grid(8'd3, 8'd3, 1'b1, 8'h66);
    send_byte(8'h21, 1'b0);
    send_byte(8'h22, 1'b0);
    set_grid(8'd2, 8'd2, 1'b0, 8'h77);
    send_byte(8'h23, 1'b1);
  endtask

  task automatic test_random_messages();
    logic [7:0] raw_r;
    logic [7:0] raw_c;
    logic [3:0] nib;
    int         cap;
    int         len;
    int         pick;
    set_grid(8'd8, 8'd8, 1'b0, 8'($urandom_range(0, 255)));
    for (int i = 0; i < CELLS; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        raw_r = 8'd8;
        raw_c = 8'd8;
      end else if (pick == 1) begin
        nib = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
        raw_r = {4'($urandom_range(0, 15)), nib};
        raw_c = {4'($urandom_range(0, 15)), 4'($urandom_range(1, 3))};
        if ($urandom_range(0, 1) == 1) {raw_r, raw_c} = {raw_c, raw_r};
      end else begin
        raw_r = {4'($urandom_range(0, 15)), 4'($urandom_range(1, 4))};
        raw_c = {4'($urandom_range(0, 15)), 4'($urandom_range(1, 4))};
      end
      set_grid(raw_r, raw_c, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      cap = int'(clamp_dim(raw_r[3:0], MAX_ROWS) * clamp_dim(raw_c[3:0], MAX_COLS));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        if (bytes_sent < RANDOM_BYTES) begin
          if ($urandom_range(0, 4) == 0) len = cap + int'($urandom_range(1, cap));
          else len = int'($urandom_range(1, cap));
          if (len > RANDOM_BYTES - bytes_sent) len = RANDOM_BYTES - bytes_sent;
          for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)),
                      (i == len - 1) || ($urandom_range(0, 19) == 0));
          if ($urandom_range(0, 3) == 0) pause_sender();
        end
      end
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_read_orders();
    test_single_cell();
    test_clamped_sizes();
    test_mid_message_changes();
    test_random_messages();
    pause_sender();
    repeat (10) @(posedge clk);
    $display("sent %0d bytes over %0d grid settings, checked %0d result beats",
             bytes_sent, settings_used, beats_checked);
    $display("both read orders, clamped and shrunk grids, padding and back-to-back beats");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/btb_pkg.sv
design/btb_ctrl.sv
design/btb_dp.sv
design/block_transposition_buffer_core.sv
tb/sv/tb.sv
